// ----- hdl/ittf_pkg.sv -----
// ----------------------------------------------------------------------------
// ittf_pkg
// Shared types, constants and lookup functions for the integer to text
// formatter: format codes, the queued item layout and the ASCII constants.
// ----------------------------------------------------------------------------
package ittf_pkg;

    localparam int WORD_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int QUEUE_DEPTH = 2;

    // Last sequencer step of each format
    localparam logic [3:0] DEC_LAST_STEP = 4'd10;
    localparam logic [3:0] OCT_LAST_STEP = 4'd11;
    localparam logic [3:0] HEX_LAST_STEP = 4'd9;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UPPER = 8'h37;  // 'A' - 10

    typedef enum logic [1:0] {
        MODE_SDEC = 2'd0,
        MODE_UDEC = 2'd1,
        MODE_OCT  = 2'd2,
        MODE_HEX  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic              neg;
        logic [WORD_W-1:0] mag;
    } t_item;

    // Decimal weight of digit position k
    function automatic logic [WORD_W-1:0] pow10(input logic [3:0] k);
        logic [WORD_W-1:0] p;
        unique case (k)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

    // Upper-case hexadecimal glyph
    function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + CHAR_W'(d);
        end else begin
            c = CH_UPPER + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// ----- hdl/ittf_word_if.sv -----
// ----------------------------------------------------------------------------
// ittf_word_if
// Input channel: one 32-bit word per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ittf_word_if;
    import ittf_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_value;

    modport source (output valid, output word_value, input ready);
    modport sink   (input valid, input word_value, output ready);
endinterface

// ----- hdl/ittf_text_if.sv -----
// ----------------------------------------------------------------------------
// ittf_text_if
// Output channel: one ASCII character per item with a last flag.
// ----------------------------------------------------------------------------
interface ittf_text_if;
    import ittf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ----- hdl/ittf_front.sv -----
// ----------------------------------------------------------------------------
// ittf_front
// Holds the format register and classifies each accepted word into a
// format, a sign and an unsigned magnitude for the back end.
// ----------------------------------------------------------------------------
module ittf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ittf_word_if.sink          i_word,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    input  logic               i_q_ready,
    output logic               o_push,
    output ittf_pkg::t_item    o_item
);
    import ittf_pkg::*;

    t_mode r_mode;
    logic  neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SDEC;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_wdata);
        end
    end

    assign i_word.ready = i_q_ready;
    assign o_push       = i_word.valid && i_q_ready;

    // Negate in signed mode only; the most negative word maps onto itself
    assign neg         = (r_mode == MODE_SDEC) && i_word.word_value[WORD_W-1];
    assign o_item.mode = r_mode;
    assign o_item.neg  = neg;
    assign o_item.mag  = neg ? (~i_word.word_value + WORD_W'(1)) : i_word.word_value;

endmodule

// ----- hdl/ittf_queue.sv -----
// ----------------------------------------------------------------------------
// ittf_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ittf_queue #(
    parameter int DEPTH = ittf_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ittf_pkg::t_item i_item,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output ittf_pkg::t_item o_item
);
    import ittf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (pop_ok) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/ittf_back.sv -----
// ----------------------------------------------------------------------------
// ittf_back
// Character sequencer: walks one digit position per cycle unless the output
// stalls, drops decimal/octal leading zeros and drives the output register.
// ----------------------------------------------------------------------------
module ittf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  ittf_pkg::t_item i_item,
    output logic            o_pop,
    ittf_text_if.source     o_text
);
    import ittf_pkg::*;

    t_mode              r_mode;
    logic               r_neg;
    logic               r_zero;
    logic [WORD_W:0]    r_work;
    logic [3:0]         r_step;
    logic               r_started;
    logic               r_busy;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;

    logic               n_emit;
    logic               n_last;
    logic               n_done;
    logic               n_started;
    logic [CHAR_W-1:0]  n_char;
    logic [WORD_W:0]    n_work;
    logic               advance;

    // Decimal digit search against the nine multiples of the position weight
    logic [3:0]         dec_pos;
    logic [WORD_W-1:0]  weight;
    logic [WORD_W+1:0]  prod [10];
    logic [3:0]         dec_digit;

    assign dec_pos = DEC_LAST_STEP - r_step;
    assign weight  = pow10(dec_pos);

    always_comb begin
        for (int d = 0; d < 10; d++) begin
            prod[d] = (WORD_W+2)'(weight) * (WORD_W+2)'(d);
        end
        dec_digit = '0;
        for (int d = 1; d < 10; d++) begin
            if ({2'b00, r_work[WORD_W-1:0]} >= prod[d]) begin
                dec_digit = 4'(d);
            end
        end
    end

    always_comb begin
        n_emit    = 1'b0;
        n_last    = 1'b0;
        n_done    = 1'b0;
        n_char    = CH_ZERO;
        n_work    = r_work;
        n_started = r_started;
        unique case (r_mode)
            MODE_SDEC, MODE_UDEC: begin
                if (r_step == '0) begin
                    n_emit = r_neg;
                    n_char = CH_MINUS;
                end else begin
                    n_last    = (dec_pos == '0);
                    n_done    = n_last;
                    n_emit    = (dec_digit != '0) || r_started || n_last;
                    n_char    = CH_ZERO + CHAR_W'(dec_digit);
                    n_work    = {1'b0, r_work[WORD_W-1:0] - prod[dec_digit][WORD_W-1:0]};
                    n_started = r_started || n_emit;
                end
            end
            MODE_OCT: begin
                if (r_step == '0) begin
                    n_emit = 1'b1;
                    n_last = r_zero;
                    n_done = r_zero;
                end else begin
                    n_last    = (r_step == OCT_LAST_STEP);
                    n_done    = n_last;
                    n_emit    = (r_work[WORD_W:WORD_W-2] != '0) || r_started;
                    n_char    = CH_ZERO + CHAR_W'(r_work[WORD_W:WORD_W-2]);
                    n_work    = r_work << 3;
                    n_started = r_started || n_emit;
                end
            end
            MODE_HEX: begin
                n_emit = 1'b1;
                if (r_step == '0) begin
                    n_char = CH_ZERO;
                end else if (r_step == 4'd1) begin
                    n_char = CH_X;
                end else begin
                    n_last = (r_step == HEX_LAST_STEP);
                    n_done = n_last;
                    n_char = hex_glyph(r_work[WORD_W:WORD_W-3]);
                    n_work = r_work << 4;
                end
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    assign advance = !r_out_valid || o_text.ready;
    assign o_pop   = i_q_valid && (!r_busy || (advance && n_done));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_busy && advance) begin
                r_out_valid <= n_emit;
            end else if (advance) begin
                r_out_valid <= 1'b0;
            end
            // Load the next item, or advance the current one by a position
            if (o_pop) begin
                r_busy    <= 1'b1;
                r_mode    <= i_item.mode;
                r_neg     <= i_item.neg;
                r_zero    <= (i_item.mag == '0);
                r_step    <= '0;
                r_started <= 1'b0;
                r_work    <= (i_item.mode == MODE_HEX) ? {i_item.mag, 1'b0}
                                                       : {1'b0, i_item.mag};
            end else if (r_busy && advance) begin
                r_step    <= r_step + 4'd1;
                r_work    <= n_work;
                r_started <= n_started;
                if (n_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && advance && n_emit) begin
            r_out_char <= n_char;
            r_out_last <= n_last;
        end
    end

    assign o_text.valid     = r_out_valid;
    assign o_text.text_char = r_out_char;
    assign o_text.last_char = r_out_last;

endmodule

// ----- hdl/integer_to_text_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_to_text_formatter
// Formats a 32-bit word as ASCII text in signed decimal, unsigned decimal,
// octal or hexadecimal, one character per output item with a last flag.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake     payload
//   i_word    in   valid/ready   word_value[31:0]
//   o_text    out  valid/ready   text_char[7:0], last_char
//   i_cfg     in   write enable  i_cfg_wdata[1:0] -> format mode
//
// One character leaves per cycle at most. The back sequencer walks each
// character position of the format: sign and ten digits in decimal, a 0
// prefix and eleven digits in octal (the prefix alone for zero), and 0x and
// eight hex digits; decimal and octal leading-zero positions give no output.
// Reset is synchronous, active low; it sets the format to signed decimal and
// empties the queue. A stalled output holds the sequencer, and the front keeps
// taking words until the queue is full.
//
module integer_to_text_formatter #(
    parameter int QUEUE_DEPTH = ittf_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ittf_word_if.sink    i_word,
    ittf_text_if.source  o_text,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_wdata
);
    import ittf_pkg::*;

    // Front to queue
    logic  push;
    t_item push_item;
    logic  q_ready;

    // Queue to back
    logic  q_valid;
    t_item q_item;
    logic  pop;

    // Classify: latch the format, split sign and magnitude
    ittf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_item      (push_item)
    );

    // Decouple: front and back stall on their own
    ittf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Generate characters, one position per cycle unless the output stalls
    ittf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_text    (o_text)
    );

endmodule
